[hw/rtl/knc_pkg.sv]
`timescale 1ns / 1ps

package knc_pkg;

  localparam int MAX_KEEP_DEFAULT = 32;
  localparam int KEY_W = 32;
  localparam int IDX_W = 32;
  localparam int TOTAL_W = 6;
  localparam int LIMIT_W = 6;
  localparam logic [LIMIT_W-1:0] KEEP_COUNT_RESET = 6'd32;

  typedef struct packed {
    logic load;        // candidate beat taken
    logic first;       // list emptied before this candidate
    logic start_emit;  // emit pass begins next cycle
    logic rotate;      // one result beat taken from a non-empty list
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic at_end;
  } stat_t;

endpackage

[hw/rtl/knc_if.sv]
`timescale 1ns / 1ps

interface knc_cand_if;
  logic                        valid;
  logic                        ready;
  logic                        first_of_query;
  logic                        last_of_query;
  logic [knc_pkg::KEY_W-1:0]   candidate_distance;
  logic [knc_pkg::IDX_W-1:0]   candidate_index;

  modport source (output valid, first_of_query, last_of_query, candidate_distance,
                  candidate_index, input ready);
  modport sink (input valid, first_of_query, last_of_query, candidate_distance,
                candidate_index, output ready);
endinterface

interface knc_kept_if;
  logic                         valid;
  logic                         ready;
  logic [knc_pkg::KEY_W-1:0]    kept_distance;
  logic [knc_pkg::IDX_W-1:0]    kept_index;
  logic [knc_pkg::TOTAL_W-1:0]  kept_total;
  logic                         last_entry;

  modport source (output valid, kept_distance, kept_index, kept_total, last_entry,
                  input ready);
  modport sink (input valid, kept_distance, kept_index, kept_total, last_entry,
                output ready);
endinterface

[hw/rtl/k_nearest_candidate_keeper.sv]
`timescale 1ns / 1ps
// The first result beat is offered the cycle after a beat with last_of_query.
// Throughput: one candidate per cycle; an emit pass takes max(1, fill) result
//   beats during which no candidate is taken (the cell row rotates once per beat).
// Reset (rst, synchronous): list empty, keep_count 32, channels idle.

module k_nearest_candidate_keeper #(
  parameter int MAX_KEEP = knc_pkg::MAX_KEEP_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        keep_count_wr,
  input  logic [knc_pkg::LIMIT_W-1:0] keep_count,
  knc_cand_if.sink                    cand,
  knc_kept_if.source                  kept
);

  knc_pkg::cmd_t  cmd;
  knc_pkg::stat_t stat;

  knc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand.valid),
    .cand_ready (cand.ready),
    .cand_first (cand.first_of_query),
    .cand_last  (cand.last_of_query),
    .kept_valid (kept.valid),
    .kept_ready (kept.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  knc_datapath #(
    .MAX_KEEP (MAX_KEEP)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .keep_count_wr   (keep_count_wr),
    .keep_count_data (keep_count),
    .cmd             (cmd),
    .stat            (stat),
    .cand_key        (cand.candidate_distance),
    .cand_idx        (cand.candidate_index),
    .kept_distance   (kept.kept_distance),
    .kept_index      (kept.kept_index),
    .kept_total      (kept.kept_total),
    .last_entry      (kept.last_entry)
  );

endmodule

[hw/rtl/knc_datapath.sv]
`timescale 1ns / 1ps

module knc_datapath #(
  parameter int MAX_KEEP = knc_pkg::MAX_KEEP_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          keep_count_wr,
  input  logic [knc_pkg::LIMIT_W-1:0]   keep_count_data,
  input  knc_pkg::cmd_t                 cmd,
  output knc_pkg::stat_t                stat,
  input  logic [knc_pkg::KEY_W-1:0]     cand_key,
  input  logic [knc_pkg::IDX_W-1:0]     cand_idx,
  output logic [knc_pkg::KEY_W-1:0]     kept_distance,
  output logic [knc_pkg::IDX_W-1:0]     kept_index,
  output logic [knc_pkg::TOTAL_W-1:0]   kept_total,
  output logic                          last_entry
);

  localparam int CW = $clog2(MAX_KEEP + 1);
  localparam int TW = (CW > knc_pkg::TOTAL_W) ? CW : knc_pkg::TOTAL_W;

  logic [knc_pkg::LIMIT_W-1:0] keep_count;
  logic [CW-1:0]               fill;
  logic [CW-1:0]               beat;
  logic [CW-1:0]               lim;
  logic [CW-1:0]               n;
  logic                        full;
  logic                        replace;
  logic [TW-1:0]               total_wide;

  logic [knc_pkg::KEY_W-1:0] keys [MAX_KEEP];
  logic [knc_pkg::IDX_W-1:0] idxs [MAX_KEEP];
  logic [MAX_KEEP-1:0]       ge;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= knc_pkg::KEEP_COUNT_RESET;
    end else if (keep_count_wr) begin
      keep_count <= keep_count_data;
    end
  end

  always_comb begin
    if (keep_count == '0) begin
      lim = CW'(1);
    end else if (32'(keep_count) > 32'(MAX_KEEP)) begin
      lim = CW'(MAX_KEEP);
    end else begin
      lim = CW'(keep_count);
    end
  end

  assign n       = cmd.first ? '0 : fill;
  assign full    = (n >= lim);
  assign replace = full && (cand_key < keys[0]);

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    logic [knc_pkg::KEY_W-1:0] key_next;
    logic [knc_pkg::IDX_W-1:0] idx_next;
    logic                      ge_prev;
    logic                      ge_nxt;
    logic [knc_pkg::KEY_W-1:0] key_up;
    logic [knc_pkg::IDX_W-1:0] idx_up;
    logic [knc_pkg::KEY_W-1:0] key_dn;
    logic [knc_pkg::IDX_W-1:0] idx_dn;

    assign ge[i] = (n > CW'(i)) && (keys[i] >= cand_key);

    if (i == 0) begin : g_head
      assign ge_prev = 1'b1;
      assign key_dn  = keys[i];
      assign idx_dn  = idxs[i];
    end else begin : g_body
      assign ge_prev = ge[i-1];
      assign key_dn  = keys[i-1];
      assign idx_dn  = idxs[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_tail
      assign ge_nxt = 1'b0;
      assign key_up = keys[0];
      assign idx_up = idxs[0];
    end else begin : g_mid
      assign ge_nxt = ge[i+1];
      assign key_up = keys[i+1];
      assign idx_up = idxs[i+1];
    end

    always_comb begin
      key_next = keys[i];
      idx_next = idxs[i];
      if (cmd.load) begin
        if (!full) begin
          if (n >= CW'(i) && !ge[i]) begin
            key_next = ge_prev ? cand_key : key_dn;
            idx_next = ge_prev ? cand_idx : idx_dn;
          end
        end else if (replace && n > CW'(i)) begin
          // drop the farthest entry, sort the candidate into the rest
          if (ge_nxt) begin
            key_next = key_up;
            idx_next = idx_up;
          end else if (ge[i] || i == 0) begin
            key_next = cand_key;
            idx_next = cand_idx;
          end
        end
      end else if (cmd.rotate && fill > CW'(i)) begin
        if (fill == CW'(i + 1)) begin
          key_next = keys[0];
          idx_next = idxs[0];
        end else begin
          key_next = key_up;
          idx_next = idx_up;
        end
      end
    end

    always_ff @(posedge clk) begin
      keys[i] <= key_next;
      idxs[i] <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      beat <= '0;
    end else begin
      if (cmd.load) begin
        fill <= full ? n : n + CW'(1);
      end
      if (cmd.start_emit) begin
        beat <= '0;
      end else if (cmd.rotate) begin
        beat <= beat + CW'(1);
      end
    end
  end

  assign stat.empty  = (fill == '0);
  assign stat.at_end = (fill == '0) || (beat == fill - CW'(1));

  assign total_wide    = TW'(fill);
  assign kept_total    = total_wide[knc_pkg::TOTAL_W-1:0];
  assign kept_distance = stat.empty ? '0 : keys[0];
  assign kept_index    = stat.empty ? '0 : idxs[0];
  assign last_entry    = stat.at_end;

endmodule

[hw/rtl/knc_ctrl.sv]
`timescale 1ns / 1ps

module knc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           cand_valid,
  output logic           cand_ready,
  input  logic           cand_first,
  input  logic           cand_last,
  output logic           kept_valid,
  input  logic           kept_ready,
  input  knc_pkg::stat_t stat,
  output knc_pkg::cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state;
  logic state_next;
  logic cand_take;
  logic kept_take;

  assign cand_ready = (state == ST_IDLE);
  assign kept_valid = (state == ST_EMIT);
  assign cand_take  = cand_valid && cand_ready;
  assign kept_take  = kept_valid && kept_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cand_take && cand_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (kept_take && stat.at_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd.load       = cand_take;
  assign cmd.first      = cand_first;
  assign cmd.start_emit = cand_take && cand_last;
  assign cmd.rotate     = kept_take && !stat.empty;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cand_ready && kept_valid))
    else $error("candidate and result channels open together");

  a_emit_follows_last: assert property (@(posedge clk) disable iff (rst)
    (cand_take && cand_last) |=> kept_valid)
    else $error("no emit after last candidate");

  a_emit_ends: assert property (@(posedge clk) disable iff (rst)
    (kept_take && stat.at_end) |=> (cand_ready && !kept_valid))
    else $error("emit did not end on final beat");

  a_empty_one_beat: assert property (@(posedge clk) disable iff (rst)
    (kept_valid && stat.empty) |-> stat.at_end)
    else $error("empty list must emit a single beat");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_KEEP = knc_pkg::MAX_KEEP_DEFAULT;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS = 135;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [knc_pkg::KEY_W-1:0]   distance;
    logic [knc_pkg::IDX_W-1:0]   index;
    logic [knc_pkg::TOTAL_W-1:0] total;
    logic                        last;
  } kept_beat_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        keep_count_wr;
  logic [knc_pkg::LIMIT_W-1:0] keep_count;

  knc_cand_if cand();
  knc_kept_if kept();

  k_nearest_candidate_keeper uut (
    .clk           (clk),
    .rst           (rst),
    .keep_count_wr (keep_count_wr),
    .keep_count    (keep_count),
    .cand          (cand),
    .kept          (kept)
  );

  // predictor state
  logic [knc_pkg::KEY_W-1:0]   near_keys [MAX_KEEP];
  logic [knc_pkg::IDX_W-1:0]   near_ids  [MAX_KEEP];
  int unsigned                 near_fill;
  logic [knc_pkg::LIMIT_W-1:0] limit_reg;
  kept_beat_t                  expected_kept[$];

  int  mismatch_count;
  int  cycle_count = 0;
  bit  src_pace;
  logic sink_pace;
  logic sink_hold;
  int  sink_wait;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned effective_keep();
    int unsigned lim;
    lim = limit_reg;
    if (lim < 1) lim = 1;
    if (lim > MAX_KEEP) lim = MAX_KEEP;
    return lim;
  endfunction

  // place behind every entry with key >= the new one
  function automatic void insert_sorted(int unsigned n, logic [knc_pkg::KEY_W-1:0] key,
                                        logic [knc_pkg::IDX_W-1:0] id);
    int unsigned pos;
    pos = 0;
    while (pos < n && near_keys[pos] >= key) pos++;
    for (int unsigned j = n; j > pos; j--) begin
      near_keys[j] = near_keys[j-1];
      near_ids[j]  = near_ids[j-1];
    end
    near_keys[pos] = key;
    near_ids[pos]  = id;
  endfunction

  function automatic void keep_candidate(logic first, logic last,
                                         logic [knc_pkg::KEY_W-1:0] key,
                                         logic [knc_pkg::IDX_W-1:0] id);
    int unsigned lim;
    kept_beat_t beat;
    lim = effective_keep();
    if (first) near_fill = 0;
    if (near_fill < lim) begin
      insert_sorted(near_fill, key, id);
      near_fill++;
    end else if (key < near_keys[0]) begin
      for (int unsigned k = 0; k + 1 < near_fill; k++) begin
        near_keys[k] = near_keys[k+1];
        near_ids[k]  = near_ids[k+1];
      end
      insert_sorted(near_fill - 1, key, id);
    end
    if (!last) return;
    if (near_fill == 0) begin
      beat = '{distance: '0, index: '0, total: '0, last: 1'b1};
      expected_kept.push_back(beat);
      return;
    end
    for (int unsigned k = 0; k < near_fill; k++) begin
      beat.distance = near_keys[k];
      beat.index    = near_ids[k];
      beat.total    = near_fill[knc_pkg::TOTAL_W-1:0];
      beat.last     = (k + 1 == near_fill);
      expected_kept.push_back(beat);
    end
  endfunction

  // ---------------------------------------------------------------- result side
  always @(posedge clk) begin : sink_pacing
    int w;
    if (rst) begin
      kept.ready <= 1'b0;
      sink_wait  <= 0;
    end else if (sink_hold) begin
      kept.ready <= 1'b0;
    end else if (kept.valid && kept.ready) begin
      w = sink_pace ? $urandom_range(0, 15) : 0;
      sink_wait  <= w;
      kept.ready <= (w == 0);
    end else if (sink_wait != 0) begin
      sink_wait  <= sink_wait - 1;
      kept.ready <= (sink_wait == 1);
    end else begin
      kept.ready <= 1'b1;
    end
  end

  task automatic report_mismatch(string what, kept_beat_t want, kept_beat_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t %s: expected %h %h %0d %b, got %h %h %0d %b",
               $realtime, what, want.distance, want.index, want.total, want.last,
               got.distance, got.index, got.total, got.last);
  endtask

  always @(posedge clk) begin : result_check
    kept_beat_t want;
    kept_beat_t got;
    if (!rst && kept.valid && kept.ready) begin
      got = '{distance: kept.kept_distance, index: kept.kept_index,
              total: kept.kept_total, last: kept.last_entry};
      if (expected_kept.size() == 0) begin
        want = '0;
        report_mismatch("unexpected beat", want, got);
      end else begin
        want = expected_kept.pop_front();
        if (got.distance !== want.distance || got.index !== want.index ||
            got.total !== want.total || got.last !== want.last)
          report_mismatch("beat mismatch", want, got);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_candidate(logic first, logic last, logic [knc_pkg::KEY_W-1:0] key,
                                logic [knc_pkg::IDX_W-1:0] id);
    int gap;
    gap = src_pace ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      cand.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cand.valid              <= 1'b1;
    cand.first_of_query     <= first;
    cand.last_of_query      <= last;
    cand.candidate_distance <= key;
    cand.candidate_index    <= id;
    @(posedge clk);
    while (!cand.ready) @(posedge clk);
    keep_candidate(first, last, key, id);
  endtask

  // drop valid, drain pending results, let any in-flight load finish
  task automatic settle_block();
    cand.valid <= 1'b0;
    while (expected_kept.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_keep_count(logic [knc_pkg::LIMIT_W-1:0] value);
    keep_count_wr <= 1'b1;
    keep_count    <= value;
    @(posedge clk);
    keep_count_wr <= 1'b0;
    limit_reg = value;
  endtask

  task automatic hold_results(int cycles);
    sink_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    sink_hold <= 1'b0;
  endtask

  function automatic logic [knc_pkg::KEY_W-1:0] random_distance();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1, 2: return $urandom_range(0, 15);
      default: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return '1;
          default: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_default_limit();
    src_pace = 0;
    sink_pace <= 1'b0;
    send_candidate(1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
    send_candidate(1'b0, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
    send_candidate(1'b0, 1'b0, 32'h8000_0000, 32'hA5A5_A5A5);
    send_candidate(1'b0, 1'b0, 32'h8000_0000, 32'h5A5A_5A5A);
    send_candidate(1'b0, 1'b1, 32'h7FFF_FFFF, 32'h0000_0001);
    // list survives the emit
    send_candidate(1'b0, 1'b1, 32'h8000_0000, 32'h0000_0002);
    send_candidate(1'b1, 1'b1, 32'h1234_5678, 32'hFFFF_FFFF);
  endtask

  task automatic test_full_replacement();
    settle_block();
    write_keep_count(6'd3);
    send_candidate(1'b1, 1'b0, 32'd10, 32'd1);
    send_candidate(1'b0, 1'b0, 32'd20, 32'd2);
    send_candidate(1'b0, 1'b0, 32'd30, 32'd3);
    send_candidate(1'b0, 1'b0, 32'd30, 32'd4);   // equal to farthest: dropped
    send_candidate(1'b0, 1'b0, 32'd20, 32'd5);   // goes behind the older 20
    send_candidate(1'b0, 1'b1, 32'd5, 32'd6);
  endtask

  task automatic test_limit_out_of_range();
    settle_block();
    write_keep_count(6'd0);                       // acts as 1
    send_candidate(1'b1, 1'b0, 32'd7, 32'd1);
    send_candidate(1'b0, 1'b0, 32'd9, 32'd2);
    send_candidate(1'b0, 1'b1, 32'd3, 32'd3);
  endtask

  task automatic test_limit_lowered_mid_query();
    settle_block();
    write_keep_count(6'd8);
    src_pace = 1;
    sink_pace <= 1'b1;
    send_candidate(1'b1, 1'b0, 32'd50, 32'd11);
    send_candidate(1'b0, 1'b0, 32'd40, 32'd12);
    send_candidate(1'b0, 1'b0, 32'd60, 32'd13);
    send_candidate(1'b0, 1'b0, 32'd45, 32'd14);
    send_candidate(1'b0, 1'b0, 32'd55, 32'd15);
    settle_block();
    write_keep_count(6'd2);                       // fill already above the limit
    send_candidate(1'b0, 1'b0, 32'd42, 32'd16);
    send_candidate(1'b0, 1'b1, 32'd70, 32'd17);
  endtask

  task automatic test_result_backpressure();
    settle_block();
    write_keep_count(6'd32);
    src_pace = 0;
    sink_pace <= 1'b0;
    fork
      hold_results(300);
      begin
        for (int i = 0; i < 32; i++)
          send_candidate(i == 0, i == 31, $urandom, $urandom);
        for (int i = 0; i < 10; i++)
          send_candidate(i == 0, i == 9, random_distance(), $urandom);
      end
    join
  endtask

  task automatic test_random_queries();
    logic [knc_pkg::LIMIT_W-1:0] keep_choices[13] = '{6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd8,
                                                      6'd12, 6'd16, 6'd32, 6'd0, 6'd63,
                                                      6'd33, 6'd1};
    int sent;
    int queries;
    int len;
    int cap;
    logic first;
    logic last;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle_block();
      keep_choices[12] = $urandom_range(1, 63);
      write_keep_count(keep_choices[$urandom_range(0, 12)]);
      src_pace = ($urandom_range(0, 3) != 0);
      sink_pace <= ($urandom_range(0, 3) != 0);
      cap = effective_keep() > 16 ? 1 : $urandom_range(2, 5);
      for (queries = 0; queries < cap; queries++) begin
        len = $urandom_range(1, effective_keep() + 5);
        for (int i = 0; i < len; i++) begin
          if (i == 0) first = ($urandom_range(0, 9) != 0);
          else first = ($urandom_range(0, 29) == 0);
          last = (i == len - 1) || ($urandom_range(0, 19) == 0);
          send_candidate(first, last, random_distance(), $urandom);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst                     <= 1'b1;
    keep_count_wr           <= 1'b0;
    keep_count              <= knc_pkg::KEEP_COUNT_RESET;
    cand.valid              <= 1'b0;
    cand.first_of_query     <= 1'b0;
    cand.last_of_query      <= 1'b0;
    cand.candidate_distance <= '0;
    cand.candidate_index    <= '0;
    sink_hold               <= 1'b0;
    sink_pace               <= 1'b0;
    mismatch_count           = 0;
    src_pace                 = 0;
    near_fill                = 0;
    limit_reg                = knc_pkg::KEEP_COUNT_RESET;
    for (int i = 0; i < MAX_KEEP; i++) begin
      near_keys[i] = '0;
      near_ids[i]  = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_default_limit();
    test_full_replacement();
    test_limit_out_of_range();
    test_limit_lowered_mid_query();
    test_result_backpressure();
    test_random_queries();

    settle_block();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_kept.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
